FILE: design/pngse_pkg.sv
`default_nettype none

package pngse_pkg;

    localparam int DIM_W      = 13;
    localparam int MAX_DIM    = 4096;
    localparam int RAW_W      = 27;
    localparam int IDX_W      = 6;
    localparam int SLOT_W     = 3;

    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES   = 32'hFFFFFFFF;
    localparam logic [16:0] ADLER_MOD  = 17'd65521;
    localparam logic [15:0] BLOCK_MAX  = 16'd65535;
    localparam logic [7:0]  ZLIB_CMF   = 8'h78;
    localparam logic [7:0]  ZLIB_FLG   = 8'h01;

    // Last index of each byte sequence
    localparam logic [IDX_W-1:0]  HDR_LAST  = 6'd42;
    localparam logic [IDX_W-1:0]  BLK_LAST  = 6'd4;
    localparam logic [IDX_W-1:0]  TRL_LAST  = 6'd19;
    localparam logic [SLOT_W-1:0] SLOT_LAST = 3'd4;

    // Register indexes on the configuration port
    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HDR,
        S_RAW,
        S_BLK,
        S_TRL
    } state_t;

    typedef enum logic [1:0] {
        SEL_HDR,
        SEL_RAW,
        SEL_BLK,
        SEL_TRL
    } sel_t;

    typedef struct packed {
        logic              start;
        logic              pix;
        logic              emit;
        sel_t              sel;
        logic [IDX_W-1:0]  idx;
        logic              last;
        logic              fin;
    } ctl_cmd_t;

    typedef struct packed {
        logic body;
        logic col_zero;
        logic raw_zero;
        logic raw_one;
        logic blk_zero;
        logic trail;
        logic out_free;
    } dp_sts_t;

    // Byte k of a 32-bit word, most significant first
    function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
        logic [7:0] b;
        case (k)
            2'd0:    b = v[31:24];
            2'd1:    b = v[23:16];
            2'd2:    b = v[15:8];
            default: b = v[7:0];
        endcase
        return b;
    endfunction

    function automatic logic [7:0] png_sig(input logic [2:0] k);
        logic [7:0] b;
        case (k)
            3'd0:    b = 8'h89;
            3'd1:    b = 8'h50;
            3'd2:    b = 8'h4E;
            3'd3:    b = 8'h47;
            3'd4:    b = 8'h0D;
            3'd5:    b = 8'h0A;
            3'd6:    b = 8'h1A;
            default: b = 8'h0A;
        endcase
        return b;
    endfunction

    // One byte into the reflected CRC-32
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: design/pngse_dp.sv
`default_nettype none

module pngse_dp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire pngse_pkg::ctl_cmd_t          cmd,
    output pngse_pkg::dp_sts_t                sts,
    input  wire logic [pngse_pkg::DIM_W-1:0]  cfg_width,
    input  wire logic [pngse_pkg::DIM_W-1:0]  cfg_height,
    input  wire logic [7:0]                   red,
    input  wire logic [7:0]                   green,
    input  wire logic [7:0]                   blue,
    input  wire logic [7:0]                   alpha,
    input  wire logic                         out_stall,
    output logic                              out_valid,
    output logic [7:0]                        out_byte,
    output logic                              last_of_run,
    output logic                              image_end
);

    localparam int DW = pngse_pkg::DIM_W;
    localparam int RW = pngse_pkg::RAW_W;

    logic          body_reg, body_next;
    logic [31:0]   crc_reg, crc_next;
    logic [15:0]   adl_lo_reg, adl_lo_next;
    logic [15:0]   adl_hi_reg, adl_hi_next;
    logic [DW-1:0] col_reg, col_next;
    logic [DW-1:0] row_reg, row_next;
    logic [15:0]   blk_left_reg, blk_left_next;
    logic [RW-1:0] raw_left_reg, raw_left_next;
    logic          trail_reg, trail_next;
    logic          out_valid_reg, out_valid_next;

    logic [7:0]    red_reg, green_reg, blue_reg, alpha_reg;
    logic [31:0]   idat_len_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg, out_end_reg;

    logic [7:0]    emit_byte;
    logic          emit_crc, emit_crc_rst;
    logic [1:0]    k;
    logic [1:0]    k1;
    logic [31:0]   crc_out;
    logic [15:0]   blk_size;
    logic [15:0]   blk_comp;
    logic          blk_final;
    logic [27:0]   raw_prod;
    logic [10:0]   blk_a;
    logic [16:0]   blk_s;
    logic [1:0]    blk_c;
    logic [11:0]   blk_cnt;
    logic [31:0]   idat_len;
    logic [16:0]   lo_sum, hi_sum;
    logic [15:0]   lo_mod, hi_mod;
    logic [DW-1:0] col_inc, row_inc;

    assign k       = cmd.idx[1:0];
    assign k1      = cmd.idx[1:0] - 2'd1;
    assign crc_out = crc_reg ^ pngse_pkg::CRC_ONES;

    // Size of a new stored block and its header fields
    assign blk_size  = (raw_left_reg < {11'd0, pngse_pkg::BLOCK_MAX}) ?
                       raw_left_reg[15:0] : pngse_pkg::BLOCK_MAX;
    assign blk_comp  = ~blk_size;
    assign blk_final = ({11'd0, blk_size} == raw_left_reg);

    // Raw byte count of the image: (4 * width + 1) * height
    assign raw_prod = {13'd0, cfg_width, 2'b01} * {15'd0, cfg_height};

    // Block count: 65536 = 1 mod 65535, so split raw into high and low halves
    assign blk_a   = raw_left_reg[26:16];
    assign blk_s   = {6'd0, blk_a} + {1'b0, raw_left_reg[15:0]};
    assign blk_c   = (blk_s == 17'd0) ? 2'd0 :
                     (blk_s <= {1'b0, pngse_pkg::BLOCK_MAX}) ? 2'd1 : 2'd2;
    assign blk_cnt = {1'b0, blk_a} + {10'd0, blk_c};
    assign idat_len = {5'd0, raw_left_reg} + ({20'd0, blk_cnt} * 32'd5) + 32'd6;

    // Adler-32 step on the emitted raw byte
    assign lo_sum = {1'b0, adl_lo_reg} + {9'd0, emit_byte};
    assign lo_mod = (lo_sum >= pngse_pkg::ADLER_MOD) ?
                    16'(lo_sum - pngse_pkg::ADLER_MOD) : lo_sum[15:0];
    assign hi_sum = {1'b0, adl_hi_reg} + {1'b0, lo_mod};
    assign hi_mod = (hi_sum >= pngse_pkg::ADLER_MOD) ?
                    16'(hi_sum - pngse_pkg::ADLER_MOD) : hi_sum[15:0];

    assign col_inc = col_reg + 1'b1;
    assign row_inc = row_reg + 1'b1;

    // Select the byte for the current sequence position
    always_comb
    begin
        emit_byte    = 8'd0;
        emit_crc     = 1'b0;
        emit_crc_rst = 1'b0;
        case (cmd.sel)
            pngse_pkg::SEL_HDR:
            begin
                case (cmd.idx) inside
                    [6'd0:6'd7]:   emit_byte = pngse_pkg::png_sig(cmd.idx[2:0]);
                    [6'd8:6'd11]:  emit_byte = pngse_pkg::be_byte(32'd13, k);
                    [6'd12:6'd15]: emit_byte = pngse_pkg::be_byte("IHDR", k);
                    [6'd16:6'd19]: emit_byte = pngse_pkg::be_byte({19'd0, cfg_width}, k);
                    [6'd20:6'd23]: emit_byte = pngse_pkg::be_byte({19'd0, cfg_height}, k);
                    6'd24:         emit_byte = 8'd8;
                    6'd25:         emit_byte = 8'd6;
                    [6'd26:6'd28]: emit_byte = 8'd0;
                    [6'd29:6'd32]: emit_byte = pngse_pkg::be_byte(crc_out, k1);
                    [6'd33:6'd36]: emit_byte = pngse_pkg::be_byte(idat_len_reg, k1);
                    [6'd37:6'd40]: emit_byte = pngse_pkg::be_byte("IDAT", k1);
                    6'd41:         emit_byte = pngse_pkg::ZLIB_CMF;
                    default:       emit_byte = pngse_pkg::ZLIB_FLG;
                endcase
                emit_crc     = ((cmd.idx >= 6'd12) && (cmd.idx <= 6'd28)) ||
                               (cmd.idx >= 6'd37);
                emit_crc_rst = (cmd.idx == 6'd12) || (cmd.idx == 6'd37);
            end
            pngse_pkg::SEL_RAW:
            begin
                case (cmd.idx[2:0])
                    3'd1:    emit_byte = red_reg;
                    3'd2:    emit_byte = green_reg;
                    3'd3:    emit_byte = blue_reg;
                    3'd4:    emit_byte = alpha_reg;
                    default: emit_byte = 8'd0;
                endcase
                emit_crc = 1'b1;
            end
            pngse_pkg::SEL_BLK:
            begin
                case (cmd.idx[2:0])
                    3'd0:    emit_byte = {7'd0, blk_final};
                    3'd1:    emit_byte = blk_size[7:0];
                    3'd2:    emit_byte = blk_size[15:8];
                    3'd3:    emit_byte = blk_comp[7:0];
                    default: emit_byte = blk_comp[15:8];
                endcase
                emit_crc = 1'b1;
            end
            default:
            begin
                case (cmd.idx) inside
                    [6'd0:6'd3]:   emit_byte = pngse_pkg::be_byte({adl_hi_reg, adl_lo_reg}, k);
                    [6'd4:6'd7]:   emit_byte = pngse_pkg::be_byte(crc_out, k);
                    [6'd8:6'd11]:  emit_byte = 8'd0;
                    [6'd12:6'd15]: emit_byte = pngse_pkg::be_byte("IEND", k);
                    default:       emit_byte = pngse_pkg::be_byte(crc_out, k);
                endcase
                emit_crc     = (cmd.idx <= 6'd3) ||
                               ((cmd.idx >= 6'd12) && (cmd.idx <= 6'd15));
                emit_crc_rst = (cmd.idx == 6'd12);
            end
        endcase
    end

    // Next state of the encoder
    always_comb
    begin
        body_next      = body_reg;
        crc_next       = crc_reg;
        adl_lo_next    = adl_lo_reg;
        adl_hi_next    = adl_hi_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        blk_left_next  = blk_left_reg;
        raw_left_next  = raw_left_reg;
        trail_next     = trail_reg;
        out_valid_next = out_valid_reg && out_stall;

        if (cmd.start)
        begin
            body_next     = 1'b1;
            adl_lo_next   = 16'd1;
            adl_hi_next   = 16'd0;
            col_next      = '0;
            row_next      = '0;
            blk_left_next = 16'd0;
            raw_left_next = raw_prod[RW-1:0];
            trail_next    = 1'b0;
        end

        // Advance column and row at pixel intake
        if (cmd.pix)
        begin
            trail_next = 1'b0;
            if (col_inc >= cfg_width)
            begin
                col_next = '0;
                row_next = row_inc;
                if (row_inc >= cfg_height)
                begin
                    trail_next = 1'b1;
                    body_next  = 1'b0;
                end
            end
            else
            begin
                col_next = col_inc;
            end
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            if (emit_crc)
            begin
                crc_next = pngse_pkg::crc_byte(emit_crc_rst ? pngse_pkg::CRC_ONES : crc_reg,
                                               emit_byte);
            end
            if (cmd.sel == pngse_pkg::SEL_RAW)
            begin
                raw_left_next = raw_left_reg - 1'b1;
                blk_left_next = blk_left_reg - 1'b1;
                adl_lo_next   = lo_mod;
                adl_hi_next   = hi_mod;
            end
            if ((cmd.sel == pngse_pkg::SEL_BLK) && (cmd.idx == pngse_pkg::BLK_LAST))
            begin
                blk_left_next = blk_size;
            end
        end
    end

    // Control and checksum state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_reg      <= 1'b0;
            crc_reg       <= pngse_pkg::CRC_ONES;
            adl_lo_reg    <= 16'd1;
            adl_hi_reg    <= 16'd0;
            col_reg       <= '0;
            row_reg       <= '0;
            blk_left_reg  <= 16'd0;
            raw_left_reg  <= '0;
            trail_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            body_reg      <= body_next;
            crc_reg       <= crc_next;
            adl_lo_reg    <= adl_lo_next;
            adl_hi_reg    <= adl_hi_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            blk_left_reg  <= blk_left_next;
            raw_left_reg  <= raw_left_next;
            trail_reg     <= trail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: pixel bytes, IDAT length, output byte
    always_ff @(posedge clk)
    begin
        idat_len_reg <= idat_len;
        if (cmd.pix)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            alpha_reg <= alpha;
        end
        if (cmd.emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= cmd.last;
            out_end_reg  <= cmd.fin;
        end
    end

    assign sts.body     = body_reg;
    assign sts.col_zero = (col_reg == '0);
    assign sts.raw_zero = (raw_left_reg == '0);
    assign sts.raw_one  = (raw_left_reg == RW'(1));
    assign sts.blk_zero = (blk_left_reg == 16'd0);
    assign sts.trail    = trail_reg;
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;
    assign image_end   = out_end_reg;

endmodule

`default_nettype wire

FILE: design/pngse_ctrl.sv
`default_nettype none

module pngse_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 func,
    input  wire pngse_pkg::dp_sts_t   sts,
    output pngse_pkg::ctl_cmd_t       cmd
);

    pngse_pkg::state_t                 state_reg, state_next;
    logic [pngse_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic [pngse_pkg::SLOT_W-1:0]      slot_reg, slot_next;
    logic                              accept;

    assign in_stall = (state_reg != pngse_pkg::S_IDLE);
    assign accept   = in_valid && !in_stall;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pngse_pkg::S_IDLE;
            idx_reg   <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            slot_reg  <= slot_next;
        end
    end

    // Sequence the bytes of each item
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        slot_next  = slot_reg;
        cmd        = '0;
        cmd.sel    = pngse_pkg::SEL_HDR;
        cmd.idx    = idx_reg;
        case (state_reg)
            pngse_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (!func)
                    begin
                        cmd.start  = 1'b1;
                        idx_next   = '0;
                        state_next = pngse_pkg::S_HDR;
                    end
                    else if (sts.body)
                    begin
                        cmd.pix    = 1'b1;
                        slot_next  = sts.col_zero ? 3'd0 : 3'd1;
                        state_next = pngse_pkg::S_RAW;
                    end
                end
            end
            pngse_pkg::S_HDR:
            begin
                cmd.sel = pngse_pkg::SEL_HDR;
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = (idx_reg == pngse_pkg::HDR_LAST);
                    if (idx_reg == pngse_pkg::HDR_LAST)
                    begin
                        state_next = pngse_pkg::S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            pngse_pkg::S_RAW:
            begin
                cmd.sel = pngse_pkg::SEL_RAW;
                cmd.idx = {3'd0, slot_reg};
                if (sts.raw_zero)
                begin
                    // Drop the rest of the pixel once the plan is used up
                    idx_next   = '0;
                    state_next = sts.trail ? pngse_pkg::S_TRL : pngse_pkg::S_IDLE;
                end
                else if (sts.blk_zero)
                begin
                    idx_next   = '0;
                    state_next = pngse_pkg::S_BLK;
                end
                else if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = !sts.trail && ((slot_reg == pngse_pkg::SLOT_LAST) || sts.raw_one);
                    if (slot_reg == pngse_pkg::SLOT_LAST)
                    begin
                        idx_next   = '0;
                        state_next = sts.trail ? pngse_pkg::S_TRL : pngse_pkg::S_IDLE;
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                end
            end
            pngse_pkg::S_BLK:
            begin
                cmd.sel = pngse_pkg::SEL_BLK;
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (idx_reg == pngse_pkg::BLK_LAST)
                    begin
                        state_next = pngse_pkg::S_RAW;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            pngse_pkg::S_TRL:
            begin
                cmd.sel = pngse_pkg::SEL_TRL;
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = (idx_reg == pngse_pkg::TRL_LAST);
                    cmd.fin  = (idx_reg == pngse_pkg::TRL_LAST);
                    if (idx_reg == pngse_pkg::TRL_LAST)
                    begin
                        state_next = pngse_pkg::S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = pngse_pkg::S_IDLE;
            end
        endcase
    end

    // Never load the output register while it holds an untaken item
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("byte emitted into a busy output register");

    // A block header is only started while planned raw bytes remain
    a_blk_raw: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pngse_pkg::S_BLK) |-> !sts.raw_zero)
        else $error("block header with no raw bytes left");

    // The file's final byte also closes its item
    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.fin) |-> cmd.last)
        else $error("image end without last flag");

    // The trailer runs only after the image body has closed
    a_trl_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pngse_pkg::S_TRL) |-> (!sts.body && sts.trail))
        else $error("trailer while image body open");

endmodule

`default_nettype wire

FILE: design/png_rgba_stored_encoder.sv
// PNG encoder for RGBA8 pixel streams using stored (uncompressed) deflate blocks.
// Input channel (in_valid/in_stall): func=0 starts a file, func=1 carries one
// pixel in red/green/blue/alpha. Output channel (out_valid/out_stall) carries
// the file one byte per item; last_of_run marks the last byte of each input
// item and image_end the final byte of the file.
// A start item yields 43 bytes (signature, IHDR, IDAT head, zlib header).
// A pixel yields its four bytes, a filter byte at each row start and a 5-byte
// block header when a new stored block opens; the last pixel adds 20 bytes
// (Adler-32, IDAT CRC, IEND). Pixels outside an image produce nothing.
// After intake the sequencer emits one byte per cycle while the output
// register is free; a new stored block adds a check step before its five
// header bytes. Each byte is registered in the output register before it is
// presented; when a block header opens first, the check step lies between
// intake and the first byte.
// in_stall is high while an item's bytes are being produced; the next item is
// taken while the last byte still waits in the output register.
// A stalled receiver holds the output register and pauses the sequencer.
// Reset sets width and height to 1 and leaves the encoder idle; write the size
// over APB (width at 0x0, height at 0x4, clamped to 1..4096) before a start.
`default_nettype none

module png_rgba_stored_encoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        func,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    input  wire logic [7:0]  alpha,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             last_of_run,
    output logic             image_end
);

    localparam int DW = pngse_pkg::DIM_W;

    logic [DW-1:0]        width_reg, height_reg;
    logic [DW-1:0]        wr_clamped;
    logic                 wr_en;
    pngse_pkg::reg_idx_t  wr_idx;
    pngse_pkg::ctl_cmd_t  cmd;
    pngse_pkg::dp_sts_t   sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = pngse_pkg::reg_idx_t'(paddr[2]);

    // Clamp written size into 1..MAX_DIM
    assign wr_clamped = (pwdata[DW-1:0] == '0) ? DW'(1) :
                        (pwdata[DW-1:0] > DW'(pngse_pkg::MAX_DIM)) ?
                        DW'(pngse_pkg::MAX_DIM) : pwdata[DW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DW'(1);
            height_reg <= DW'(1);
        end
        else if (wr_en)
        begin
            case (wr_idx)
                pngse_pkg::REG_WIDTH:  width_reg  <= wr_clamped;
                pngse_pkg::REG_HEIGHT: height_reg <= wr_clamped;
                default:               width_reg  <= width_reg;
            endcase
        end
    end

    // Read back the selected register (low address bits ignored)
    assign prdata = (wr_idx == pngse_pkg::REG_HEIGHT) ? {19'd0, height_reg} :
                    {19'd0, width_reg} | {29'd0, paddr[1:0] & 2'b00, 1'b0};

    pngse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .sts      (sts),
        .cmd      (cmd)
    );

    pngse_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_width   (width_reg),
        .cfg_height  (height_reg),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .image_end   (image_end)
    );

endmodule

`default_nettype wire

FILE: tb/png_stored_checker.sv
`default_nettype none

module png_stored_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        func,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,
    input  wire logic [7:0]  alpha,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [7:0]  out_byte,
    input  wire logic        last_of_run,
    input  wire logic        image_end,
    output int               errors,
    output int               pending,
    output int               files_done
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fin;
    } file_byte_t;

    // Expected file bytes, oldest first
    file_byte_t   file_bytes_q[$];
    logic [7:0]   item_bytes[$];

    // Shadow of the encoder state
    logic [pngse_pkg::DIM_W-1:0] cfg_width;
    logic [pngse_pkg::DIM_W-1:0] cfg_height;
    bit                          in_image;
    logic [31:0]                 crc_acc;
    int unsigned                 adler_lo;
    int unsigned                 adler_hi;
    logic [pngse_pkg::DIM_W-1:0] col_cnt;
    logic [pngse_pkg::DIM_W-1:0] row_cnt;
    logic [15:0]                 blk_left;
    logic [pngse_pkg::RAW_W-1:0] raw_left;

    function automatic logic [pngse_pkg::DIM_W-1:0] clamp_size(input logic [31:0] v);
        logic [12:0] d;
        d = v[12:0];
        if (d == 0)
            return 13'd1;
        if (d > pngse_pkg::MAX_DIM)
            return 13'(pngse_pkg::MAX_DIM);
        return d;
    endfunction

    task automatic emit(input logic [7:0] b, input bit in_crc);
        logic [31:0] c;
        item_bytes = {item_bytes, b};
        if (in_crc)
        begin
            c = crc_acc ^ {24'd0, b};
            for (int i = 0; i < 8; i++)
                c = (c >> 1) ^ (32'hEDB88320 & {32{c[0]}});
            crc_acc = c;
        end
    endtask

    task automatic emit_word(input logic [31:0] v, input bit in_crc);
        for (int i = 3; i >= 0; i--)
            emit(v[i*8 +: 8], in_crc);
    endtask

    task automatic emit_tag(input string tag);
        crc_acc = 32'hFFFFFFFF;
        for (int i = 0; i < 4; i++)
            emit(tag[i], 1'b1);
    endtask

    // Raw byte: opens a stored block when needed, feeds Adler-32
    task automatic emit_raw(input logic [7:0] b);
        logic [15:0] sz;
        logic [15:0] comp;
        if (raw_left == 0)
            return;
        if (blk_left == 0)
        begin
            sz = (raw_left < 65535) ? raw_left[15:0] : 16'hFFFF;
            comp = ~sz;
            emit((27'(sz) == raw_left) ? 8'h01 : 8'h00, 1'b1);
            emit(sz[7:0], 1'b1);
            emit(sz[15:8], 1'b1);
            emit(comp[7:0], 1'b1);
            emit(comp[15:8], 1'b1);
            blk_left = sz;
        end
        emit(b, 1'b1);
        blk_left--;
        raw_left--;
        adler_lo = (adler_lo + b) % 65521;
        adler_hi = (adler_hi + adler_lo) % 65521;
    endtask

    task automatic begin_file();
        longint unsigned raw;
        longint unsigned blocks;
        longint unsigned idat_len;
        raw = (longint'(cfg_width) * 4 + 1) * longint'(cfg_height);
        blocks = (raw + 65534) / 65535;
        idat_len = 2 + raw + 5 * blocks + 4;
        emit(8'h89, 0); emit(8'h50, 0); emit(8'h4E, 0); emit(8'h47, 0);
        emit(8'h0D, 0); emit(8'h0A, 0); emit(8'h1A, 0); emit(8'h0A, 0);
        emit_word(32'd13, 0);
        emit_tag("IHDR");
        emit_word(32'(cfg_width), 1);
        emit_word(32'(cfg_height), 1);
        emit(8'd8, 1); emit(8'd6, 1); emit(8'd0, 1); emit(8'd0, 1); emit(8'd0, 1);
        emit_word(crc_acc ^ 32'hFFFFFFFF, 0);
        emit_word(idat_len[31:0], 0);
        emit_tag("IDAT");
        emit(8'h78, 1);
        emit(8'h01, 1);
        in_image = 1;
        adler_lo = 1;
        adler_hi = 0;
        col_cnt = 0;
        row_cnt = 0;
        blk_left = 0;
        raw_left = raw[pngse_pkg::RAW_W-1:0];
    endtask

    task automatic predict_item(input logic f, input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic [7:0] a);
        bit done;
        file_byte_t e;
        done = 0;
        item_bytes.delete();
        if (!f)
            begin_file();
        else if (in_image)
        begin
            if (col_cnt == 0)
                emit_raw(8'h00);
            emit_raw(r);
            emit_raw(g);
            emit_raw(b);
            emit_raw(a);
            col_cnt = col_cnt + 1;
            if (col_cnt >= cfg_width)
            begin
                col_cnt = 0;
                row_cnt = row_cnt + 1;
                if (row_cnt >= cfg_height)
                begin
                    emit_word({adler_hi[15:0], adler_lo[15:0]}, 1);
                    emit_word(crc_acc ^ 32'hFFFFFFFF, 0);
                    emit_word(32'd0, 0);
                    emit_tag("IEND");
                    emit_word(crc_acc ^ 32'hFFFFFFFF, 0);
                    done = 1;
                    in_image = 0;
                end
            end
        end
        for (int k = 0; k < item_bytes.size(); k++)
        begin
            e.data = item_bytes[k];
            e.last = (k == item_bytes.size() - 1);
            e.fin = e.last && done;
            file_bytes_q = {file_bytes_q, e};
        end
    endtask

    // Compare outputs, then track config writes and accepted items
    always @(posedge clk or negedge rst_n)
    begin
        file_byte_t want;
        if (!rst_n)
        begin
            cfg_width = 1;
            cfg_height = 1;
            in_image = 0;
            crc_acc = 32'hFFFFFFFF;
            adler_lo = 1;
            adler_hi = 0;
            col_cnt = 0;
            row_cnt = 0;
            blk_left = 0;
            raw_left = 0;
            file_bytes_q.delete();
            errors = 0;
            pending = 0;
            files_done = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (file_bytes_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected byte %02h last %0b end %0b",
                                 $realtime, out_byte, last_of_run, image_end);
                end
                else
                begin
                    want = file_bytes_q.pop_front();
                    if (want.fin && image_end)
                        files_done++;
                    if (want.data !== out_byte || want.last !== last_of_run
                        || want.fin !== image_end)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: byte mismatch exp %02h/%0b/%0b got %02h/%0b/%0b",
                                     $realtime, want.data, want.last, want.fin,
                                     out_byte, last_of_run, image_end);
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                if (pngse_pkg::reg_idx_t'(paddr[2]) == pngse_pkg::REG_WIDTH)
                    cfg_width = clamp_size(pwdata);
                else
                    cfg_height = clamp_size(pwdata);
            end
            if (in_valid && !in_stall)
                predict_item(func, red, green, blue, alpha);
            pending = file_bytes_q.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/png_rgba_stored_encoder_test.sv
`default_nettype none

module png_rgba_stored_encoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 0;
    logic        in_stall;
    logic        func = 0;
    logic [7:0]  red = 0;
    logic [7:0]  green = 0;
    logic [7:0]  blue = 0;
    logic [7:0]  alpha = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic        image_end;

    int errors;
    int pending;
    int files_done;
    int items_sent = 0;
    bit quiet = 0;
    int stall_left = 0;
    bit stall_on = 0;

    always #6 clk = ~clk;

    png_rgba_stored_encoder dut (.*);

    png_stored_checker chk (.*);

    // Receiver stalls in random bursts
    always @(negedge clk)
    begin
        if (quiet)
            out_stall <= 0;
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else
        begin
            stall_on = ($urandom_range(0, 2) == 0);
            stall_left <= stall_on ? $urandom_range(1, 18) : $urandom_range(1, 30);
            out_stall <= stall_on;
        end
    end

    task automatic reg_write(input pngse_pkg::reg_idx_t idx, input int unsigned value);
        @(negedge clk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    // Hold until every expected byte is out, then let the sequencer settle
    task automatic drain();
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic send_item(input logic f, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input logic [7:0] a);
        bit taken;
        taken = 0;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        in_valid <= 1;
        func <= f;
        red <= r;
        green <= g;
        blue <= b;
        alpha <= a;
        while (!taken)
        begin
            @(posedge clk);
            taken = !in_stall;
        end
        @(negedge clk);
        in_valid <= 0;
        items_sent++;
    endtask

    task automatic send_pixel();
        send_item(1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic full_image(input int w, input int h);
        drain();
        reg_write(pngse_pkg::REG_WIDTH, w);
        reg_write(pngse_pkg::REG_HEIGHT, h);
        send_item(0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        repeat (w * h) send_pixel();
    endtask

    initial
    begin
        #30ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int pick;
        repeat (3) @(negedge clk);
        rst_n = 1;

        // Stray pixel, then a 1x1 file at reset size with extreme bytes
        send_item(1, 8'hFF, 8'h00, 8'hFF, 8'h00);
        send_item(0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

        // Zero sizes clamp to one
        drain();
        reg_write(pngse_pkg::REG_WIDTH, 0);
        reg_write(pngse_pkg::REG_HEIGHT, 0);
        send_item(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

        // Oversize clamps to the maximum; abandon that file with a new start
        drain();
        reg_write(pngse_pkg::REG_WIDTH, 32'h1FFF);
        reg_write(pngse_pkg::REG_HEIGHT, 32'hFFFF_FFFF);
        send_item(0, 0, 0, 0, 0);
        send_pixel();
        send_pixel();
        full_image(3, 2);

        // Width grows mid-file: late raw bytes are dropped
        full_image(1, 1);
        drain();
        full_image(1, 1);
        drain();
        send_item(0, 0, 0, 0, 0);
        drain();
        reg_write(pngse_pkg::REG_WIDTH, 2);
        send_pixel();
        send_pixel();

        // Height shrinks mid-file: the next row end closes the file
        full_image(2, 3);
        drain();
        send_item(0, 0, 0, 0, 0);
        send_pixel();
        send_pixel();
        drain();
        reg_write(pngse_pkg::REG_HEIGHT, 1);
        send_pixel();
        send_pixel();

        // Pause the sender until every byte is out
        drain();

        // Random small files with some noise
        while (items_sent < 120)
        begin
            if (items_sent > 100)
                quiet = 1;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                full_image($urandom_range(1, 4), $urandom_range(1, 3));
            else if (pick == 7)
                send_pixel();
            else
            begin
                full_image(1, 1);
                drain();
                reg_write(pngse_pkg::REG_WIDTH, $urandom_range(2, 4));
                reg_write(pngse_pkg::REG_HEIGHT, $urandom_range(1, 3));
                send_item(0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                repeat ($urandom_range(0, 3)) send_pixel();
            end
        end

        drain();
        $display("Sent %0d items; %0d complete files checked byte by byte,", items_sent,
                 files_done);
        $display("including size clamping, stray pixels and mid-file size changes.");
        if (errors == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: png_rgba_stored_encoder.f
design/pngse_pkg.sv
design/pngse_dp.sv
design/pngse_ctrl.sv
design/png_rgba_stored_encoder.sv
tb/png_stored_checker.sv
tb/png_rgba_stored_encoder_test.sv
